/* rtl/wsg_pkg.sv */
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared constants, codes and the quarter-wave sine table builder for the
// waveform sample generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

   // table geometry
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);

   // field widths
   localparam int AMP_W       = 16;
   localparam int INDEX_W     = 24;
   localparam int LENGTH_W    = 24;
   localparam int LEVEL_W     = 27;
   localparam int RAMP_STEP_W = 25;
   localparam int PHASE_W     = 32;
   localparam int PERIOD_W    = 24;
   localparam int SAW_STEP_W  = 26;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // fixed-point constants
   localparam logic [LEVEL_W-1:0] ONE_Q24   = LEVEL_W'(1) << 24;
   localparam logic [AMP_W-1:0]   AMP_MAX   = 16'h7FFF;
   localparam logic [AMP_W-1:0]   AMP_ZERO  = 16'h0000;
   localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

   // wave modes
   typedef enum logic [1:0] {
      MODE_RAMP_UP   = 2'd0,
      MODE_RAMP_DOWN = 2'd1,
      MODE_SINE      = 2'd2,
      MODE_SAWTOOTH  = 2'd3
   } wave_mode_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAVE_MODE    = 3'd0,
      CSR_TRACK_LENGTH = 3'd1,
      CSR_RAMP_STEP    = 3'd2,
      CSR_PHASE_STEP   = 3'd3,
      CSR_SAW_PERIOD   = 3'd4,
      CSR_SAW_STEP     = 3'd5
   } csr_index_type;

   typedef logic [AMP_W-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   // one table entry: taylor series to x^15 in Q2.30, products truncated
   function automatic logic [AMP_W-1:0] sine_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] scaled;
      x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      scaled = (sum * 64'd32767 + 64'd536870912) >> 30;
      if (scaled > 64'd32767) begin
         scaled = 64'd32767;
      end
      return scaled[AMP_W-1:0];
   endfunction

   // whole table, evaluated at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         rom[k] = sine_entry(k);
      end
      return rom;
   endfunction

endpackage

/* rtl/wsg_req_if.sv */
// ----------------------------------------------------------------------------
// wsg_req_if
// Tick channel: one word per requested sample, carrying the restart flag.
// ----------------------------------------------------------------------------
interface wsg_req_if ();

   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);

endinterface

/* rtl/wsg_rsp_if.sv */
// ----------------------------------------------------------------------------
// wsg_rsp_if
// Sample channel: one word per produced sample of the track.
// ----------------------------------------------------------------------------
interface wsg_rsp_if import wsg_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic signed [AMP_W-1:0]   amplitude;
   logic        [INDEX_W-1:0] sample_index;
   logic                      last_sample;

   modport source (output valid, output amplitude, output sample_index,
                   output last_sample, input ready);
   modport sink   (input valid, input amplitude, input sample_index,
                   input last_sample, output ready);

endinterface

/* rtl/wsg_csr_if.sv */
// ----------------------------------------------------------------------------
// wsg_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wsg_csr_if import wsg_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);

endinterface

/* rtl/waveform_sample_generator_core.sv */
// ----------------------------------------------------------------------------
// waveform_sample_generator_core
// Track sample generator: ramp up, ramp down, sine and sawtooth in Q1.15.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    restart
//   rsp_if   out  valid/ready    amplitude, sample_index, last_sample
//   csr_if   in   valid/ready    index, data (ready always high)
//
// One tick word is taken per cycle while req_if.ready is high; its sample
// passes the first stage for the accumulator update and sine table read,
// then the sine sign fold into the output register.
// Reset (synchronous) restores register defaults and leaves the track idle.
// Ticks with no active track and no restart give no sample.
// A stalled output holds its word; req_if.ready drops only with both stages full.
// ----------------------------------------------------------------------------
module waveform_sample_generator_core import wsg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wsg_req_if.sink   req_if,
   wsg_rsp_if.source rsp_if,
   wsg_csr_if.sink   csr_if
);

   typedef struct packed {
      logic               is_sine;
      logic               negate;
      logic               peak;
      logic [AMP_W-1:0]   amp;
      logic [INDEX_W-1:0] index;
      logic               last;
   } stage_type;

   // configuration registers
   wave_mode_type           mode_ff;
   logic [LENGTH_W-1:0]     length_ff;
   logic [RAMP_STEP_W-1:0]  ramp_step_ff;
   logic [PHASE_W-1:0]      phase_step_ff;
   logic [PERIOD_W-1:0]     period_ff;
   logic [SAW_STEP_W-1:0]   saw_step_ff;

   // track state
   logic                    active_ff, active_in;
   logic [INDEX_W-1:0]      counter_ff, counter_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;
   logic [PERIOD_W-1:0]     saw_ff, saw_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;

   // pipeline
   logic                    s1_valid_ff, s1_valid_in;
   stage_type               s1_ff, s1_in;
   logic                    out_valid_ff;
   logic signed [AMP_W-1:0] amp_ff, amp_in;
   logic [INDEX_W-1:0]      index_ff;
   logic                    last_ff;

   logic                    req_fire;
   logic                    emit_c;
   logic                    out_free;
   logic                    last_c;
   logic [INDEX_W-1:0]      eff_counter_c;
   logic [LEVEL_W-1:0]      eff_level_c;
   logic [PERIOD_W-1:0]     eff_saw_c;
   logic [PHASE_W-1:0]      eff_phase_c;
   logic [LENGTH_W-1:0]     len_m1_c;
   logic [PERIOD_W-1:0]     period_c;
   logic [LEVEL_W:0]        round_c;
   logic [LEVEL_W-9:0]      level_q15_c;
   logic [AMP_W-1:0]        ramp_amp_c;
   logic [AMP_W-1:0]        saw_amp_c;
   logic [LEVEL_W:0]        ramp_sum_c;
   logic [LEVEL_W:0]        saw_sum_c;
   logic [PERIOD_W:0]       saw_next_c;
   logic [SINE_ADDR_W-1:0]  k_c;
   logic [SINE_ADDR_W-1:0]  rom_addr_c;
   logic [AMP_W-1:0]        rom_data;
   logic [AMP_W-1:0]        mag_c;

   // handshakes
   assign req_fire      = req_if.valid && req_if.ready;
   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !s1_valid_ff || out_free;
   assign csr_if.ready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RAMP_UP;
         length_ff     <= LENGTH_W'(1);
         ramp_step_ff  <= '0;
         phase_step_ff <= '0;
         period_ff     <= PERIOD_W'(2);
         saw_step_ff   <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_index_type'(csr_if.index))
            CSR_WAVE_MODE:    mode_ff       <= wave_mode_type'(csr_if.data[1:0]);
            CSR_TRACK_LENGTH: length_ff     <= csr_if.data[LENGTH_W-1:0];
            CSR_RAMP_STEP:    ramp_step_ff  <= csr_if.data[RAMP_STEP_W-1:0];
            CSR_PHASE_STEP:   phase_step_ff <= csr_if.data[PHASE_W-1:0];
            CSR_SAW_PERIOD:   period_ff     <= csr_if.data[PERIOD_W-1:0];
            CSR_SAW_STEP:     saw_step_ff   <= csr_if.data[SAW_STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // restart view of the state
   assign emit_c        = req_if.restart || active_ff;
   assign eff_counter_c = req_if.restart ? '0 : counter_ff;
   assign eff_saw_c     = req_if.restart ? '0 : saw_ff;
   assign eff_phase_c   = req_if.restart ? '0 : phase_ff;
   assign eff_level_c   = !req_if.restart ? level_ff :
                          (mode_ff == MODE_RAMP_DOWN) ? ONE_Q24 : '0;

   // final sample test, zero length acts as one
   assign len_m1_c = (length_ff == '0) ? '0 : length_ff - LENGTH_W'(1);
   assign last_c   = eff_counter_c >= len_m1_c;
   assign period_c = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   // level to Q1.15, halves round up
   assign round_c     = {1'b0, eff_level_c} + (LEVEL_W + 1)'(256);
   assign level_q15_c = round_c[LEVEL_W:9];
   assign ramp_amp_c  = (level_q15_c > (LEVEL_W - 8)'(32767)) ? AMP_MAX
                                                             : level_q15_c[AMP_W-1:0];
   assign saw_amp_c   = (level_q15_c >= (LEVEL_W - 8)'(65535)) ? AMP_MAX
                      : {~level_q15_c[AMP_W-1], level_q15_c[AMP_W-2:0]};

   // saturating level sums
   assign ramp_sum_c = {1'b0, eff_level_c} + (LEVEL_W + 1)'(ramp_step_ff);
   assign saw_sum_c  = {1'b0, eff_level_c} + (LEVEL_W + 1)'(saw_step_ff);
   assign saw_next_c = {1'b0, eff_saw_c} + (PERIOD_W + 1)'(1);

   // sine table address, second and fourth quadrants mirrored
   assign k_c        = eff_phase_c[PHASE_W-3 -: SINE_ADDR_W];
   assign rom_addr_c = eff_phase_c[PHASE_W-2] ? (SINE_ADDR_W'(0) - k_c) : k_c;

   // next state and first-stage word
   always_comb begin
      counter_in = eff_counter_c;
      level_in   = eff_level_c;
      saw_in     = eff_saw_c;
      phase_in   = eff_phase_c;
      active_in  = !last_c;
      if (!last_c) begin
         counter_in = eff_counter_c + INDEX_W'(1);
      end

      s1_valid_in   = req_fire && emit_c;
      s1_in.is_sine = 1'b0;
      s1_in.negate  = eff_phase_c[PHASE_W-1];
      s1_in.peak    = eff_phase_c[PHASE_W-2] && (k_c == '0);
      s1_in.amp     = ramp_amp_c;
      s1_in.index   = eff_counter_c;
      s1_in.last    = last_c;

      case (mode_ff)
         MODE_RAMP_UP: begin
            s1_in.amp = last_c ? AMP_MAX : ramp_amp_c;
            level_in  = ramp_sum_c[LEVEL_W] ? '1 : ramp_sum_c[LEVEL_W-1:0];
         end
         MODE_RAMP_DOWN: begin
            s1_in.amp = last_c ? AMP_ZERO : ramp_amp_c;
            level_in  = (eff_level_c > LEVEL_W'(ramp_step_ff))
                      ? eff_level_c - LEVEL_W'(ramp_step_ff) : '0;
         end
         MODE_SINE: begin
            s1_in.is_sine = 1'b1;
            phase_in      = eff_phase_c + phase_step_ff;
         end
         MODE_SAWTOOTH: begin
            s1_in.amp = saw_amp_c;
            if (saw_next_c >= {1'b0, period_c}) begin
               saw_in   = '0;
               level_in = '0;
            end else begin
               saw_in   = saw_next_c[PERIOD_W-1:0];
               level_in = saw_sum_c[LEVEL_W] ? '1 : saw_sum_c[LEVEL_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // track state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         counter_ff <= '0;
         level_ff   <= '0;
         saw_ff     <= '0;
         phase_ff   <= '0;
      end else if (req_fire && emit_c) begin
         active_ff  <= active_in;
         counter_ff <= counter_in;
         level_ff   <= level_in;
         saw_ff     <= saw_in;
         phase_ff   <= phase_in;
      end
   end

   wsg_sine_rom u_sine_rom (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rom_addr_c),
      .rd_data (rom_data)
   );

   // first stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // sine sign fold
   assign mag_c  = s1_ff.peak ? AMP_MAX : rom_data;
   assign amp_in = !s1_ff.is_sine ? signed'(s1_ff.amp)
                 : s1_ff.negate ? -signed'(mag_c) : signed'(mag_c);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         amp_ff   <= amp_in;
         index_ff <= s1_ff.index;
         last_ff  <= s1_ff.last;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.amplitude    = amp_ff;
   assign rsp_if.sample_index = index_ff;
   assign rsp_if.last_sample  = last_ff;

`ifndef NO_ASSERTIONS
   // the final sample closes the track
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_fire && emit_c && last_c |=> !active_ff)
      else $error("track still active after final sample");

   // sample position advances by one per produced sample
   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && emit_c && !last_c |=> counter_ff == $past(eff_counter_c) + INDEX_W'(1))
      else $error("sample counter did not advance by one");

   // tick channel stalls only with both stages holding words
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> s1_valid_ff && out_valid_ff)
      else $error("tick channel stalled with a free stage");
`endif

endmodule

/* rtl/wsg_sine_rom.sv */
// ----------------------------------------------------------------------------
// wsg_sine_rom
// Quarter-wave sine table, Q1.15 magnitudes, with a registered read port.
// ----------------------------------------------------------------------------
module wsg_sine_rom import wsg_pkg::*; (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [SINE_ADDR_W-1:0] rd_addr,
   output logic [AMP_W-1:0]       rd_data
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [AMP_W-1:0] rd_data_ff;

   // synchronous read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/waveform_sample_generator_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_sample_generator_core_test
// Self-checking bench for the track sample generator. A bit-true predictor
// follows every accepted tick word and queues the sample it should cause;
// each sample word leaving the block is checked against the oldest one.
// Registers are rewritten between phases that vary the four wave modes,
// lengths, steps and periods, and the idling of both channels.
// ----------------------------------------------------------------------------
module waveform_sample_generator_core_test;
   import wsg_pkg::*;

   localparam int          HALF_PERIOD   = 6;
   localparam int          SETTLE_CYCLES = 6;
   localparam int          SAMPLE_GOAL   = 1950;
   localparam int          SPAN_CAP      = 48;
   localparam bit [63:0]   RIGHT_ANGLE_Q30 = 64'd1686629713;
   localparam logic [LEVEL_W-1:0] LEVEL_CAP = '1;
   localparam logic [31:0] UNIT_Q24 = 32'd16777216;

   typedef struct packed {
      logic [AMP_W-1:0]   amplitude;
      logic [INDEX_W-1:0] index;
      logic               last;
   } sample_word_type;

   // predictor of the generator plus the queue of samples still owed
   class sample_scoreboard_type;
      wave_mode_type          mode;
      logic [LENGTH_W-1:0]    track_len;
      logic [RAMP_STEP_W-1:0] ramp_inc;
      logic [PHASE_W-1:0]     phase_inc;
      logic [PERIOD_W-1:0]    saw_len;
      logic [SAW_STEP_W-1:0]  saw_inc;
      logic [INDEX_W-1:0]     count;
      bit                     active;
      logic [LEVEL_W-1:0]     level;
      int unsigned            saw_pos;
      logic [PHASE_W-1:0]     phase;
      logic [AMP_W-1:0]       quarter_sine [SINE_TABLE_DEPTH];
      sample_word_type        pending [$];
      int unsigned            produced;
      int unsigned            errors;

      function new();
         bit [63:0] x;
         bit [63:0] term;
         bit [63:0] sum;
         // quarter-wave table: taylor series to x^15 in Q2.30, truncating
         for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            x    = (RIGHT_ANGLE_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            term = x;
            sum  = x;
            for (int n = 1; n <= 7; n++) begin
               term = (term * x) >> 30;
               term = (term * x) >> 30;
               term = term / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
            sum = (sum * 64'd32767 + 64'd536870912) >> 30;
            quarter_sine[k] = (sum > 64'd32767) ? 16'd32767 : sum[15:0];
         end
         mode      = MODE_RAMP_UP;
         track_len = 1;
         ramp_inc  = '0;
         phase_inc = '0;
         saw_len   = 2;
         saw_inc   = '0;
         count     = '0;
         active    = 0;
         level     = '0;
         saw_pos   = 0;
         phase     = '0;
         produced  = 0;
         errors    = 0;
      endfunction

      function void report(string msg);
         errors++;
         $display("%0t ns: mismatch: %s", $time, msg);
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_WAVE_MODE:    mode      = wave_mode_type'(data[1:0]);
            CSR_TRACK_LENGTH: track_len = data[LENGTH_W-1:0];
            CSR_RAMP_STEP:    ramp_inc  = data[RAMP_STEP_W-1:0];
            CSR_PHASE_STEP:   phase_inc = data[PHASE_W-1:0];
            CSR_SAW_PERIOD:   saw_len   = data[PERIOD_W-1:0];
            CSR_SAW_STEP:     saw_inc   = data[SAW_STEP_W-1:0];
            default: ;
         endcase
      endfunction

      // Q.24 level to Q1.15, halves rounded up, saturating at full scale
      function int level_amp(logic [LEVEL_W-1:0] lvl);
         int unsigned v;
         v = (32'(lvl) + 32'd256) >> 9;
         return (v > 32767) ? 32767 : int'(v);
      endfunction

      function logic [LEVEL_W-1:0] level_sum(logic [LEVEL_W-1:0] a, int unsigned b);
         bit [63:0] s;
         s = 64'(a) + 64'(b);
         return (s > 64'(LEVEL_CAP)) ? LEVEL_CAP : s[LEVEL_W-1:0];
      endfunction

      // quadrant fold of the quarter-wave table
      function int sine_amp(logic [PHASE_W-1:0] ph);
         logic [SINE_ADDR_W-1:0] k;
         int                     mag;
         k = ph[29 -: SINE_ADDR_W];
         if (ph[30]) begin
            mag = (k == 0) ? 32767 : int'(quarter_sine[SINE_TABLE_DEPTH - int'(k)]);
         end else begin
            mag = int'(quarter_sine[k]);
         end
         return ph[31] ? -mag : mag;
      endfunction

      // one accepted tick word
      function void note_tick(bit restart);
         int unsigned     len_eff;
         int unsigned     period_eff;
         bit              last;
         int              amp;
         int              v;
         sample_word_type w;
         len_eff    = (track_len == 0) ? 1 : int'(track_len);
         period_eff = (saw_len == 0) ? 1 : int'(saw_len);
         if (restart) begin
            count   = '0;
            saw_pos = 0;
            phase   = '0;
            level   = (mode == MODE_RAMP_DOWN) ? ONE_Q24 : '0;
            active  = 1;
         end else if (!active) begin
            return;
         end
         last = (count >= len_eff - 1);
         case (mode)
            MODE_RAMP_UP: begin
               amp   = last ? 32767 : level_amp(level);
               level = level_sum(level, ramp_inc);
            end
            MODE_RAMP_DOWN: begin
               amp   = last ? 0 : level_amp(level);
               level = (level > ramp_inc) ? level - ramp_inc : '0;
            end
            MODE_SINE: begin
               amp   = sine_amp(phase);
               phase = phase + phase_inc;
            end
            default: begin
               v   = int'((32'(level) + 32'd256) >> 9) - 32768;
               amp = (v > 32767) ? 32767 : v;
               saw_pos++;
               if (saw_pos >= period_eff) begin
                  saw_pos = 0;
                  level   = '0;
               end else begin
                  level = level_sum(level, saw_inc);
               end
            end
         endcase
         w.amplitude = amp[AMP_W-1:0];
         w.index     = count;
         w.last      = last;
         pending.push_back(w);
         produced++;
         if (last) begin
            active = 0;
         end else begin
            count = count + 1'b1;
         end
      endfunction

      // one accepted sample word
      function void check_sample(sample_word_type got);
         sample_word_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected sample amplitude %0d index %0d last %0b",
                             $signed(got.amplitude), got.index, got.last));
            return;
         end
         want = pending.pop_front();
         if (got.amplitude !== want.amplitude) begin
            report($sformatf("index %0d amplitude %0d, expected %0d", want.index,
                             $signed(got.amplitude), $signed(want.amplitude)));
         end
         if (got.index !== want.index) begin
            report($sformatf("sample_index %0d, expected %0d", got.index, want.index));
         end
         if (got.last !== want.last) begin
            report($sformatf("index %0d last_sample %0b, expected %0b", want.index,
                             got.last, want.last));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   int unsigned          sender_pct;
   int unsigned          stall_pct;
   sample_scoreboard_type sb;

   wsg_req_if req_if ();
   wsg_rsp_if rsp_if ();
   wsg_csr_if csr_if ();

   waveform_sample_generator_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // clock
   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // sample monitor
   always @(posedge clock) begin
      sample_word_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.amplitude = rsp_if.amplitude;
         got.index     = rsp_if.sample_index;
         got.last      = rsp_if.last_sample;
         sb.check_sample(got);
      end
   end

   // one tick word, with random idle cycles ahead of it
   task automatic send_tick(bit restart);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_tick(restart);
   endtask

   // stop ticking and let the pipeline empty
   task automatic settle();
      @(negedge clock) req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_config(logic [31:0] mode, logic [31:0] len, logic [31:0] ramp,
                               logic [31:0] ph, logic [31:0] per, logic [31:0] saw);
      program_reg(CSR_WAVE_MODE, mode);
      program_reg(CSR_TRACK_LENGTH, len);
      program_reg(CSR_RAMP_STEP, ramp);
      program_reg(CSR_PHASE_STEP, ph);
      program_reg(CSR_SAW_PERIOD, per);
      program_reg(CSR_SAW_STEP, saw);
      @(negedge clock) csr_if.valid <= 1'b0;
   endtask

   task automatic send_track(bit restart, int unsigned advances);
      send_tick(restart);
      repeat (advances) send_tick(1'b0);
   endtask

   // junk above the register width now and then
   function automatic logic [31:0] with_noise(logic [31:0] v, int w);
      if (w < 32 && $urandom_range(0, 4) == 0) begin
         return v | ($urandom << w);
      end
      return v;
   endfunction

   // random register set, biased toward the extremes
   task automatic random_config();
      logic [31:0] mode;
      logic [31:0] len;
      logic [31:0] ramp;
      logic [31:0] ph;
      logic [31:0] per;
      logic [31:0] saw;
      int unsigned len_eff;
      int unsigned per_eff;
      mode = 32'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
         0:       len = 32'd0;
         1:       len = 32'd1;
         2:       len = 32'hFF_FFFF;
         3:       len = 32'($urandom_range(49, 24'hFF_FFFF));
         default: len = 32'($urandom_range(2, 40));
      endcase
      len_eff = (len == 0) ? 1 : len;
      case ($urandom_range(0, 5))
         0:       ramp = UNIT_Q24;
         1:       ramp = 32'd0;
         2:       ramp = 32'h1FF_FFFF;
         3:       ramp = 32'($urandom_range(0, 32'h1FF_FFFF));
         default: ramp = (len_eff > 1) ? UNIT_Q24 / (len_eff - 1) : UNIT_Q24;
      endcase
      case ($urandom_range(0, 6))
         0:       ph = 32'd0;
         1:       ph = 32'hFFFF_FFFF;
         2:       ph = 32'h4000_0000;
         3:       ph = 32'($urandom_range(1, 32'h100_0000));
         default: ph = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0:       per = 32'd0;
         1:       per = 32'd1;
         2:       per = 32'hFF_FFFF;
         default: per = 32'($urandom_range(2, 24));
      endcase
      per_eff = (per == 0) ? 1 : per;
      case ($urandom_range(0, 5))
         0:       saw = 32'd0;
         1:       saw = 32'h3FF_FFFF;
         2:       saw = 2 * UNIT_Q24;
         3:       saw = 32'($urandom_range(0, 32'h3FF_FFFF));
         default: saw = (per_eff > 1) ? 2 * UNIT_Q24 / (per_eff - 1) : 2 * UNIT_Q24;
      endcase
      apply_config(with_noise(mode, 2), with_noise(len, LENGTH_W),
                   with_noise(ramp, RAMP_STEP_W), ph, with_noise(per, PERIOD_W),
                   with_noise(saw, SAW_STEP_W));
   endtask

   // run limit
   initial begin
      #(5_000_000);
      $display("waveform_sample_generator_core_test: FAIL");
      $finish;
   end

   // stimulus
   initial begin
      int unsigned phase_no;
      int unsigned goal;
      int unsigned span;
      int unsigned pick;
      sb             = new();
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_WAVE_MODE;
      csr_if.data    = '0;
      sender_pct     = 0;
      stall_pct      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // idle tick, then a one-sample track on the reset registers
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);

      // ramp up in quarter steps, final sample forced to full scale
      settle();
      apply_config(32'(MODE_RAMP_UP), 32'd5, UNIT_Q24 / 4, 32'd0, 32'd2, 32'd0);
      send_track(1'b1, 4);

      // ramp down with a full-scale step: saturated start, floor at zero
      settle();
      apply_config(32'(MODE_RAMP_DOWN), 32'd4, UNIT_Q24, 32'd0, 32'd2, 32'd0);
      send_track(1'b1, 3);

      // sine at quarter turns hits every quadrant boundary
      settle();
      apply_config(32'(MODE_SINE), 32'd6, 32'd0, 32'h4000_0000, 32'd2, 32'd0);
      send_track(1'b1, 5);

      // zero length and zero period: single samples pinned at -1.0
      settle();
      apply_config(32'(MODE_SAWTOOTH), 32'd0, 32'd0, 32'd0, 32'd0, 2 * UNIT_Q24);
      send_track(1'b1, 0);
      send_track(1'b1, 0);

      // sawtooth with the largest step saturates, then wraps
      settle();
      apply_config(32'(MODE_SAWTOOTH), 32'd5, 32'd0, 32'd0, 32'd3, 32'h3FF_FFFF);
      send_track(1'b1, 4);

      // random phases, rotating through the idling patterns
      phase_no = 0;
      while (sb.produced < SAMPLE_GOAL) begin
         settle();
         case (phase_no % 4)
            0: begin sender_pct = 0;  stall_pct = 0;  end
            1: begin sender_pct = 86; stall_pct = 0;  end
            2: begin sender_pct = 0;  stall_pct = 86; end
            default: begin sender_pct = 31; stall_pct = 31; end
         endcase
         random_config();
         span = (sb.track_len == 0) ? 1 : sb.track_len;
         if (span > SPAN_CAP) begin
            span = SPAN_CAP;
         end
         goal = sb.produced + $urandom_range(40, 160);
         if (goal > SAMPLE_GOAL) begin
            goal = SAMPLE_GOAL;
         end
         while (sb.produced < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               send_track(1'b1, span - 1);
            end else if (pick < 92) begin
               // cut short by the next restart
               send_track(1'b1, $urandom_range(0, span - 1));
            end else begin
               send_track(1'b0, $urandom_range(0, 3));
            end
         end
         phase_no++;
      end

      sender_pct = 0;
      stall_pct  = 0;
      settle();
      if (sb.pending.size() != 0) begin
         sb.report($sformatf("%0d samples never arrived", sb.pending.size()));
      end
      if (sb.errors == 0) begin
         $display("waveform_sample_generator_core_test: PASS");
      end else begin
         $display("waveform_sample_generator_core_test: FAIL");
      end
      $finish;
   end

endmodule
